// ===== rtl/core/i2cms_pkg.sv =====
// Shared types, codes and reset constants of the I2C master bit sequencer.
package i2cms_pkg;

	localparam int unsigned RegW  = 8;
	localparam int unsigned IdxW  = 2;
	localparam int unsigned OpW   = 3;
	localparam int unsigned BitCntW = 4;

	// Reset values of the configuration registers, and the MSB mask
	localparam logic [RegW-1:0] SetupTicksRst   = 8'd4;
	localparam logic [RegW-1:0] HalfBitTicksRst = 8'd2;
	localparam logic [RegW-1:0] SampleTicksRst  = 8'd1;
	localparam logic [RegW-1:0] AckPollLimRst   = 8'd250;
	localparam logic [RegW-1:0] MsbMask         = 8'h80;

	typedef enum logic [IdxW-1:0] {
		REG_SETUP_TICKS    = 2'd0,
		REG_HALF_BIT_TICKS = 2'd1,
		REG_SAMPLE_TICKS   = 2'd2,
		REG_ACK_POLL_LIMIT = 2'd3
	} reg_idx_t;

	typedef enum logic [OpW-1:0] {
		OP_TICK     = 3'd0,
		OP_START    = 3'd1,
		OP_STOP     = 3'd2,
		OP_WRITE    = 3'd3,
		OP_READ     = 3'd4,
		OP_WAIT_ACK = 3'd5
	} op_t;

	typedef enum logic [14:0] {
		PH_IDLE    = 15'h0001,
		PH_START_A = 15'h0002,
		PH_START_B = 15'h0004,
		PH_STOP_A  = 15'h0008,
		PH_STOP_B  = 15'h0010,
		PH_W_SETUP = 15'h0020,
		PH_W_HIGH  = 15'h0040,
		PH_W_LOW   = 15'h0080,
		PH_R_LOW   = 15'h0100,
		PH_R_HIGH  = 15'h0200,
		PH_A_LOW   = 15'h0400,
		PH_A_HIGH  = 15'h0800,
		PH_K_REL   = 15'h1000,
		PH_K_SCLH  = 15'h2000,
		PH_K_POLL  = 15'h4000
	} phase_t;

	// A programmed delay of zero still lasts one tick
	function automatic logic [RegW-1:0] ticks_of(input logic [RegW-1:0] d);
		return (d == '0) ? RegW'(1) : d;
	endfunction

endpackage

// ===== rtl/core/i2cms_ifs.sv =====
// Command and result channel interfaces of the I2C master bit sequencer.
interface i2cms_cmd_if;
	import i2cms_pkg::*;
	logic           valid;
	logic           ready;
	logic [OpW-1:0] op;
	logic [7:0]     tx_byte;
	logic           send_ack;
	logic           sda_in;

	modport source (output valid, op, tx_byte, send_ack, sda_in, input ready);
	modport sink   (input valid, op, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cms_res_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda_out;
	logic       sda_enable;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_failed;
	logic       rejected;

	modport source (output valid, scl, sda_out, sda_enable, busy_res, done_res, rx_byte,
		ack_failed, rejected, input ready);
	modport sink   (input valid, scl, sda_out, sda_enable, busy_res, done_res, rx_byte,
		ack_failed, rejected, output ready);
endinterface

// ===== rtl/core/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer: command/tick sequencer with a registered result stage.
// Result: the result of an accepted transaction is registered and valid in the cycle after acceptance.
// Throughput: one transaction per cycle unless a pending result stalls; sequencer
// state and result register update together: only the result register sets the rate.
// Reset (arst_n low): idle, SCL high, SDA driven high, delays back to defaults,
// no result pending.
module i2c_master_bit_sequencer
	import i2cms_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IdxW-1:0]   cfg_index,
	input  logic [RegW-1:0]   cfg_data,
	i2cms_cmd_if.sink         cmd,
	i2cms_res_if.source       res
);

	// Configuration registers
	logic [RegW-1:0] setup_q, half_q, sample_q, limit_q;

	// Sequencer state
	phase_t             phase_q, n_phase;
	logic [RegW-1:0]    delay_q, n_delay;
	logic [BitCntW-1:0] bit_q, n_bit;
	logic [7:0]         shift_q, n_shift;
	logic               ack_mode_q, n_ack_mode;
	logic [RegW-1:0]    poll_q, n_poll;
	logic               scl_q, n_scl, sda_q, n_sda, en_q, n_en;
	logic               fail_q, n_fail;
	logic [7:0]         rx_q, n_rx;

	// Per-transaction flags
	logic            done, rej, do_poll;
	logic [RegW-1:0] poll_base;
	logic            is_cmd, take;

	// Result register
	logic       out_valid_q;
	logic       o_scl_q, o_sda_q, o_en_q, o_busy_q, o_done_q, o_fail_q, o_rej_q;
	logic [7:0] o_rx_q;

	assign cmd.ready = !out_valid_q || res.ready;
	assign take      = cmd.valid && cmd.ready;
	assign is_cmd    = (cmd.op >= OP_START) && (cmd.op <= OP_WAIT_ACK);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q  <= SetupTicksRst;
			half_q   <= HalfBitTicksRst;
			sample_q <= SampleTicksRst;
			limit_q  <= AckPollLimRst;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SETUP_TICKS:    setup_q  <= cfg_data;
				REG_HALF_BIT_TICKS: half_q   <= cfg_data;
				REG_SAMPLE_TICKS:   sample_q <= cfg_data;
				REG_ACK_POLL_LIMIT: limit_q  <= cfg_data;
				default:            ;
			endcase
		end
	end

	// Compute the next sequencer state for one transaction
	always_comb begin
		n_phase    = phase_q;
		n_delay    = delay_q;
		n_bit      = bit_q;
		n_shift    = shift_q;
		n_ack_mode = ack_mode_q;
		n_poll     = poll_q;
		n_scl      = scl_q;
		n_sda      = sda_q;
		n_en       = en_q;
		n_fail     = fail_q;
		n_rx       = rx_q;
		done       = 1'b0;
		rej        = 1'b0;
		do_poll    = 1'b0;
		poll_base  = poll_q;

		if (is_cmd && phase_q == PH_IDLE) begin
			// Accept a new command
			n_fail = 1'b0;
			n_bit  = '0;
			n_poll = '0;
			case (op_t'(cmd.op))
				OP_START: begin
					n_en = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
					n_phase = PH_START_A; n_delay = ticks_of(setup_q);
				end
				OP_STOP: begin
					n_scl = 1'b0; n_en = 1'b1; n_sda = 1'b0;
					n_phase = PH_STOP_A; n_delay = ticks_of(setup_q);
				end
				OP_WRITE: begin
					n_shift = cmd.tx_byte;
					n_en = 1'b1; n_scl = 1'b0;
					n_sda = |(cmd.tx_byte & MsbMask);
					n_phase = PH_W_SETUP; n_delay = ticks_of(half_q);
				end
				OP_READ: begin
					n_shift = '0;
					n_ack_mode = cmd.send_ack;
					n_en = 1'b0; n_sda = 1'b1; n_scl = 1'b0;
					n_phase = PH_R_LOW; n_delay = ticks_of(half_q);
				end
				default: begin
					n_en = 1'b0; n_sda = 1'b1;
					n_phase = PH_K_REL; n_delay = RegW'(1);
				end
			endcase
		end else if (phase_q != PH_IDLE) begin
			// Advance the waveform by one tick
			rej = is_cmd;
			if (phase_q == PH_K_POLL) begin
				do_poll = 1'b1;
			end else if (delay_q > RegW'(1)) begin
				n_delay = delay_q - RegW'(1);
			end else begin
				n_delay = '0;
				unique case (phase_q)
					PH_START_A: begin
						n_sda = 1'b0; n_phase = PH_START_B; n_delay = ticks_of(setup_q);
					end
					PH_START_B: begin
						n_scl = 1'b0; n_phase = PH_IDLE; done = 1'b1;
					end
					PH_STOP_A: begin
						n_scl = 1'b1; n_sda = 1'b1;
						n_phase = PH_STOP_B; n_delay = ticks_of(setup_q);
					end
					PH_STOP_B: begin
						n_phase = PH_IDLE; done = 1'b1;
					end
					PH_W_SETUP: begin
						n_scl = 1'b1; n_phase = PH_W_HIGH; n_delay = ticks_of(half_q);
					end
					PH_W_HIGH: begin
						n_scl = 1'b0; n_phase = PH_W_LOW; n_delay = ticks_of(half_q);
					end
					PH_W_LOW: begin
						n_bit = bit_q + BitCntW'(1);
						if (n_bit >= BitCntW'(8)) begin
							n_phase = PH_IDLE; done = 1'b1;
						end else begin
							n_shift = {shift_q[6:0], 1'b0};
							n_sda   = shift_q[6];
							n_phase = PH_W_SETUP; n_delay = ticks_of(half_q);
						end
					end
					PH_R_LOW: begin
						n_scl   = 1'b1;
						n_shift = {shift_q[6:0], cmd.sda_in};
						n_phase = PH_R_HIGH; n_delay = ticks_of(sample_q);
					end
					PH_R_HIGH: begin
						n_bit = bit_q + BitCntW'(1);
						n_scl = 1'b0;
						if (n_bit < BitCntW'(8)) begin
							n_phase = PH_R_LOW; n_delay = ticks_of(half_q);
						end else begin
							n_rx  = shift_q;
							n_en  = 1'b1;
							n_sda = !ack_mode_q;
							n_phase = PH_A_LOW; n_delay = ticks_of(half_q);
						end
					end
					PH_A_LOW: begin
						n_scl = 1'b1; n_phase = PH_A_HIGH; n_delay = ticks_of(half_q);
					end
					PH_A_HIGH: begin
						n_scl = 1'b0; n_phase = PH_IDLE; done = 1'b1;
					end
					PH_K_REL: begin
						n_scl = 1'b1; n_phase = PH_K_SCLH; n_delay = RegW'(1);
					end
					PH_K_SCLH: begin
						n_phase = PH_K_POLL; n_poll = '0;
						poll_base = '0; do_poll = 1'b1;
					end
					default: begin
						n_phase = PH_IDLE; done = 1'b1;
					end
				endcase
			end

			// Sample SDA for the slave's acknowledge
			if (do_poll) begin
				if (!cmd.sda_in) begin
					n_scl = 1'b0; n_phase = PH_IDLE; n_delay = '0; done = 1'b1;
				end else if (poll_base >= limit_q) begin
					n_fail = 1'b1;
					n_scl = 1'b0; n_en = 1'b1; n_sda = 1'b0;
					n_phase = PH_STOP_A; n_delay = ticks_of(setup_q);
				end else begin
					n_poll = poll_base + RegW'(1);
				end
			end
		end
	end

	// Update sequencer state on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			delay_q    <= '0;
			bit_q      <= '0;
			shift_q    <= '0;
			ack_mode_q <= 1'b0;
			poll_q     <= '0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			en_q       <= 1'b1;
			fail_q     <= 1'b0;
			rx_q       <= '0;
		end else if (take) begin
			phase_q    <= n_phase;
			delay_q    <= n_delay;
			bit_q      <= n_bit;
			shift_q    <= n_shift;
			ack_mode_q <= n_ack_mode;
			poll_q     <= n_poll;
			scl_q      <= n_scl;
			sda_q      <= n_sda;
			en_q       <= n_en;
			fail_q     <= n_fail;
			rx_q       <= n_rx;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			o_scl_q  <= n_scl;
			o_sda_q  <= n_sda;
			o_en_q   <= n_en;
			o_busy_q <= (n_phase != PH_IDLE);
			o_done_q <= done;
			o_rx_q   <= n_rx;
			o_fail_q <= n_fail;
			o_rej_q  <= rej;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.scl        = o_scl_q;
	assign res.sda_out    = o_sda_q;
	assign res.sda_enable = o_en_q;
	assign res.busy_res   = o_busy_q;
	assign res.done_res   = o_done_q;
	assign res.rx_byte    = o_rx_q;
	assign res.ack_failed = o_fail_q;
	assign res.rejected   = o_rej_q;

endmodule

// ===== rtl/core/i2cms_checker.sv =====
// Port-level checker of the I2C master bit sequencer and its bind.
module i2cms_checker
	import i2cms_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	i2cms_cmd_if.sink   cmd,
	i2cms_res_if.source res
);

	// Stalled result holds its RX byte, SCL and done flag
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.rx_byte) && $stable(res.scl)
			&& $stable(res.done_res))
		else $error("result changed while stalled");

	// Empty result register never blocks commands
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> cmd.ready)
		else $error("command blocked with empty result register");

	// Every accepted transaction yields a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> res.valid)
		else $error("accepted transaction produced no result");

	// A finished sequence leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.done_res |-> !res.busy_res)
		else $error("done reported while still busy");

	// Released SDA reads as high
	a_release_high: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.sda_enable |-> res.sda_out)
		else $error("SDA released with low data level");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.cmd    (cmd),
	.res    (res)
);
